@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define SLT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never hold outside reset.
`define SLT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

@@ rtl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the stack language tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam logic [4:0] K_INT   = 5'd0;
   localparam logic [4:0] K_CHR   = 5'd1;
   localparam logic [4:0] K_IDN   = 5'd2;
   localparam logic [4:0] K_ADD   = 5'd3;
   localparam logic [4:0] K_SUB   = 5'd4;
   localparam logic [4:0] K_MUL   = 5'd5;
   localparam logic [4:0] K_DIV   = 5'd6;
   localparam logic [4:0] K_MOD   = 5'd7;
   localparam logic [4:0] K_PUT   = 5'd8;
   localparam logic [4:0] K_OUT   = 5'd9;
   localparam logic [4:0] K_DUP2  = 5'd10;
   localparam logic [4:0] K_ROT   = 5'd11;
   localparam logic [4:0] K_SWP   = 5'd12;
   localparam logic [4:0] K_INV   = 5'd13;
   localparam logic [4:0] K_DMP   = 5'd14;
   localparam logic [4:0] K_DUP   = 5'd15;
   localparam logic [4:0] K_DROP  = 5'd16;
   localparam logic [4:0] K_IF    = 5'd17;
   localparam logic [4:0] K_END   = 5'd18;
   localparam logic [4:0] K_GR    = 5'd19;
   localparam logic [4:0] K_GE    = 5'd20;
   localparam logic [4:0] K_EQ    = 5'd21;
   localparam logic [4:0] K_LE    = 5'd22;
   localparam logic [4:0] K_LT    = 5'd23;
   localparam logic [4:0] K_NT    = 5'd24;
   localparam logic [4:0] K_EOF   = 5'd25;
   localparam logic [4:0] K_CHERR = 5'd26;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DOLLAR= 8'h24;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LT    = 8'h3C;

   // byte classes from the front end
   localparam logic [2:0] C_OTHER = 3'd0;
   localparam logic [2:0] C_DIGIT = 3'd1;
   localparam logic [2:0] C_BLANK = 3'd2;
   localparam logic [2:0] C_NL    = 3'd3;
   localparam logic [2:0] C_EQ    = 3'd4;
   localparam logic [2:0] C_QUOTE = 3'd5;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [63:0] token_value;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       is_final;
      logic [2:0] byte_class;
      logic [4:0] op_kind;   // single-byte operator kind, K_EOF when none
   } cls_type;

   // keyword lookup; word packed big-endian into 64 bits
   function automatic logic [4:0] kw_kind(input logic [63:0] w, input logic [3:0] len);
      logic [4:0] k;
      k = K_IDN;
      if (len == 4'd3) begin
         if (w == 64'h6F7574) k = K_OUT;
         else if (w == 64'h707574) k = K_PUT;
         else if (w == 64'h647570) k = K_DUP;
         else if (w == 64'h726F74) k = K_ROT;
         else if (w == 64'h656E64) k = K_END;
      end else if (len == 4'd4) begin
         if (w == 64'h64756D70) k = K_DMP;
         else if (w == 64'h64757032) k = K_DUP2;
         else if (w == 64'h73776170) k = K_SWP;
         else if (w == 64'h64726F70) k = K_DROP;
      end else if (len == 4'd2) begin
         if (w == 64'h6966) k = K_IF;
      end
      return k;
   endfunction

endpackage

@@ rtl/slt_front.sv @@
// ----------------------------------------------------------------------------
// slt_front
// Accepts source bytes, classifies them and pushes them into a small queue.
// ----------------------------------------------------------------------------
module slt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slt_pkg::req_type  req_data,
   output logic              q_valid,
   input  logic              q_pop,
   output slt_pkg::cls_type  q_data
);
   localparam int DEPTH = 4;

   slt_pkg::cls_type  mem_ff [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   slt_pkg::cls_type  cls;
   logic push;

   always_comb begin
      cls.source_byte = req_data.source_byte;
      cls.is_final    = req_data.is_final;
      cls.op_kind     = slt_pkg::K_EOF;
      unique case (req_data.source_byte)
         8'h2B: cls.op_kind = slt_pkg::K_ADD;
         8'h2D: cls.op_kind = slt_pkg::K_SUB;
         8'h2A: cls.op_kind = slt_pkg::K_MUL;
         8'h2F: cls.op_kind = slt_pkg::K_DIV;
         8'h25: cls.op_kind = slt_pkg::K_MOD;
         8'h3D: cls.op_kind = slt_pkg::K_EQ;
         8'h21: cls.op_kind = slt_pkg::K_NT;
         default: cls.op_kind = slt_pkg::K_EOF;
      endcase
      if (req_data.source_byte >= 8'h30 && req_data.source_byte <= 8'h39)
         cls.byte_class = slt_pkg::C_DIGIT;
      else if (req_data.source_byte == slt_pkg::CH_SP ||
               req_data.source_byte == slt_pkg::CH_TAB)
         cls.byte_class = slt_pkg::C_BLANK;
      else if (req_data.source_byte == slt_pkg::CH_NL)
         cls.byte_class = slt_pkg::C_NL;
      else if (req_data.source_byte == slt_pkg::CH_EQ)
         cls.byte_class = slt_pkg::C_EQ;
      else if (req_data.source_byte == slt_pkg::CH_QUOTE)
         cls.byte_class = slt_pkg::C_QUOTE;
      else
         cls.byte_class = slt_pkg::C_OTHER;
   end

   assign req_stall = (cnt_ff == 3'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 3'd0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push  ? wr_ff + 2'd1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= cls;
   end
endmodule

@@ rtl/slt_back.sv @@
// ----------------------------------------------------------------------------
// slt_back
// Scanner state machine: turns classified bytes into up to three tokens,
// delivered one per cycle through an output register unless rsp_stall holds.
// ----------------------------------------------------------------------------
module slt_back #(
   parameter int POSITION_BITS     = 16,
   parameter int WORD_PREFIX_CHARS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  slt_pkg::cls_type  q_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slt_pkg::rsp_type  rsp_data
);
   localparam logic [2:0] M_IDLE = 3'd0, M_COMMENT = 3'd1, M_NUMBER = 3'd2, M_WORD = 3'd3,
                          M_CHAR1 = 3'd4, M_CHAR2 = 3'd5, M_GREATER = 3'd6, M_LESS = 3'd7;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam int WB = 8 * WORD_PREFIX_CHARS;

   logic [2:0]  mode_ff, mode_in;
   logic [63:0] acc_ff, acc_in;
   logic        bad_ff, bad_in;
   logic [WB-1:0] word_ff, word_in;
   logic [3:0]  wlen_ff, wlen_in;
   logic [7:0]  chr_ff, chr_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in, col_t;

   // result buffer: up to three tokens for one byte
   slt_pkg::rsp_type buf_ff [3], buf_in [3];
   logic [1:0] bcnt_ff, bcnt_in, bidx_ff, bidx_in;
   logic [1:0] n;

   logic [7:0] b;
   logic [2:0] bc;
   logic consumed, go, out_free;
   logic [67:0] sum;

   // output register
   logic rv_ff, rv_in;
   slt_pkg::rsp_type rd_ff, rd_in;

   function automatic logic [POSITION_BITS-1:0] inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction
   function automatic logic [POSITION_BITS-1:0] line_t(input logic [POSITION_BITS-1:0] v);
      return v;
   endfunction
   function automatic logic [4:0] kw(input logic [WB-1:0] w, input logic [3:0] l);
      return (l < 4'(WORD_PREFIX_CHARS)) ? slt_pkg::kw_kind(64'(w), l) : slt_pkg::K_IDN;
   endfunction
   function automatic logic [4:0] word_kind();
      return kw(word_ff, wlen_ff);
   endfunction

   assign b  = q_data.source_byte;
   assign bc = q_data.byte_class;
   assign out_free = !rv_ff || !rsp_stall;
   assign go = q_valid && (bcnt_ff == 2'd0);
   assign q_pop = go;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;
   assign sum = {4'd0, acc_ff} * 68'd10 + {64'd0, b[3:0]};

   always_comb begin
      mode_in = mode_ff; acc_in = acc_ff; bad_in = bad_ff; word_in = word_ff;
      wlen_in = wlen_ff; chr_in = chr_ff; line_in = line_ff; col_t = col_ff;
      consumed = 1'b0; n = 2'd0;
      for (int i = 0; i < 3; i++) buf_in[i] = buf_ff[i];
      if (go) begin
         unique case (mode_ff)
            M_GREATER, M_LESS: begin
               if (bc == slt_pkg::C_EQ) begin
                  consumed = 1'b1;
                  buf_in[n] = '{(mode_ff == M_GREATER) ? slt_pkg::K_GE : slt_pkg::K_LE,
                                64'd0, 16'(line_t(line_ff)), 16'(col_t), 1'b0};
               end else
                  buf_in[n] = '{(mode_ff == M_GREATER) ? slt_pkg::K_GR : slt_pkg::K_LT,
                                64'd0, 16'(line_ff), 16'(col_t), 1'b0};
               n = n + 2'd1; col_t = inc(col_t); mode_in = M_IDLE;
            end
            M_COMMENT: begin
               if (bc == slt_pkg::C_NL) mode_in = M_IDLE;
               else consumed = 1'b1;
            end
            M_NUMBER: begin
               if (bc == slt_pkg::C_BLANK || bc == slt_pkg::C_NL) begin
                  buf_in[n] = '{bad_ff ? slt_pkg::K_INV : slt_pkg::K_INT,
                                bad_ff ? 64'd0 : acc_ff, 16'(line_ff), 16'(col_t), 1'b0};
                  n = n + 2'd1; col_t = inc(col_t); mode_in = M_IDLE;
               end else begin
                  consumed = 1'b1;
                  if (bc != slt_pkg::C_DIGIT) bad_in = 1'b1;
                  else if (!bad_ff) begin
                     if (sum[67:64] != 4'd0) bad_in = 1'b1;
                     else acc_in = sum[63:0];
                  end
               end
            end
            M_WORD: begin
               if (bc == slt_pkg::C_BLANK || bc == slt_pkg::C_NL) begin
                  buf_in[n] = '{word_kind(), 64'd0, 16'(line_ff), 16'(col_t), 1'b0};
                  n = n + 2'd1; col_t = inc(col_t); mode_in = M_IDLE;
               end else begin
                  consumed = 1'b1;
                  if (wlen_ff < 4'(WORD_PREFIX_CHARS)) begin
                     word_in = {word_ff[WB-9:0], b};
                     wlen_in = wlen_ff + 4'd1;
                  end
               end
            end
            M_CHAR1: begin
               chr_in = b; mode_in = M_CHAR2; consumed = 1'b1;
            end
            M_CHAR2: begin
               buf_in[n] = (bc == slt_pkg::C_QUOTE) ?
                  '{slt_pkg::K_CHR, {56'd0, chr_ff}, 16'(line_ff), 16'(col_t), 1'b0} :
                  '{slt_pkg::K_CHERR, 64'd0, 16'(line_ff), 16'(col_t), 1'b0};
               n = n + 2'd1; col_t = inc(col_t); mode_in = M_IDLE; consumed = 1'b1;
            end
            default: mode_in = M_IDLE;
         endcase
         if (!consumed) begin
            mode_in = M_IDLE;
            if (bc == slt_pkg::C_NL) begin
               line_in = inc(line_ff); col_t = '0;
            end else if (b == slt_pkg::CH_DOLLAR) mode_in = M_COMMENT;
            else if (bc == slt_pkg::C_BLANK) col_t = inc(col_t);
            else if (q_data.op_kind != slt_pkg::K_EOF) begin
               buf_in[n] = '{q_data.op_kind, 64'd0, 16'(line_ff), 16'(col_t), 1'b0};
               n = n + 2'd1; col_t = inc(col_t);
            end else if (b == slt_pkg::CH_GT) mode_in = M_GREATER;
            else if (b == slt_pkg::CH_LT) mode_in = M_LESS;
            else if (bc == slt_pkg::C_DIGIT) begin
               mode_in = M_NUMBER; acc_in = {60'd0, b[3:0]}; bad_in = 1'b0;
            end else if (bc == slt_pkg::C_QUOTE) mode_in = M_CHAR1;
            else begin
               mode_in = M_WORD; word_in = WB'(b); wlen_in = 4'd1;
            end
         end
         if (q_data.is_final) begin
            unique case (mode_in)
               M_NUMBER: begin
                  buf_in[n] = '{bad_in ? slt_pkg::K_INV : slt_pkg::K_INT,
                                bad_in ? 64'd0 : acc_in, 16'(line_in), 16'(col_t), 1'b0};
                  n = n + 2'd1; col_t = inc(col_t);
               end
               M_WORD: begin
                  buf_in[n] = '{kw(word_in, wlen_in), 64'd0, 16'(line_in), 16'(col_t), 1'b0};
                  n = n + 2'd1; col_t = inc(col_t);
               end
               M_GREATER, M_LESS: begin
                  buf_in[n] = '{(mode_in == M_GREATER) ? slt_pkg::K_GR : slt_pkg::K_LT,
                                64'd0, 16'(line_in), 16'(col_t), 1'b0};
                  n = n + 2'd1; col_t = inc(col_t);
               end
               M_CHAR1, M_CHAR2: begin
                  buf_in[n] = '{slt_pkg::K_CHERR, 64'd0, 16'(line_in), 16'(col_t), 1'b0};
                  n = n + 2'd1; col_t = inc(col_t);
               end
               default: ;
            endcase
            buf_in[n] = '{slt_pkg::K_EOF, 64'd0, 16'(line_in), 16'(col_t), 1'b0};
            n = n + 2'd1;
            mode_in = M_IDLE; acc_in = '0; bad_in = 1'b0; word_in = '0; wlen_in = '0;
            chr_in = '0; line_in = '0; col_t = '0;
         end
         if (n != 2'd0) buf_in[n - 2'd1].last_of_run = 1'b1;
      end
   end
   assign col_in = col_t;

   // drain buffer into the output register
   always_comb begin
      rv_in = rv_ff && rsp_stall;
      rd_in = rd_ff;
      bcnt_in = go ? n : bcnt_ff;
      bidx_in = go ? 2'd0 : bidx_ff;
      if (!go && bcnt_ff != 2'd0 && out_free) begin
         rv_in = 1'b1;
         rd_in = buf_ff[bidx_ff];
         if (bidx_ff + 2'd1 == bcnt_ff) begin
            bcnt_in = 2'd0; bidx_in = 2'd0;
         end else bidx_in = bidx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; acc_ff <= '0; bad_ff <= 1'b0; word_ff <= '0; wlen_ff <= '0;
         chr_ff <= '0; line_ff <= '0; col_ff <= '0;
         bcnt_ff <= '0; bidx_ff <= '0; rv_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in; acc_ff <= acc_in; bad_ff <= bad_in; word_ff <= word_in;
         wlen_ff <= wlen_in; chr_ff <= chr_in; line_ff <= line_in; col_ff <= col_in;
         bcnt_ff <= bcnt_in; bidx_ff <= bidx_in; rv_ff <= rv_in;
      end
      rd_ff <= rd_in;
      for (int i = 0; i < 3; i++) buf_ff[i] <= buf_in[i];
   end
endmodule

@@ rtl/stack_language_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// stack_language_tokenizer_core
// Streaming tokenizer for a small stack language, one source byte per request.
// ----------------------------------------------------------------------------
// One byte is taken per request; the front end classifies it and queues it
// (4 entries), the back end scans it and stages up to three tokens, which
// leave through a registered output one per cycle unless rsp_stall holds.
// A byte yielding no token leaves the scanner free for the next byte; a
// byte yielding tokens holds it until its buffer drains, so throughput is
// one byte per cycle on operator-light text; otherwise the drain sets it.
`include "assert_macros.svh"

module stack_language_tokenizer_core #(
   parameter int POSITION_BITS     = 16,
   parameter int WORD_PREFIX_CHARS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slt_pkg::rsp_type  rsp_data
);
   logic             q_valid, q_pop;
   slt_pkg::cls_type q_data;

   // front end: accept and classify
   slt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_data
   );

   // back end: scan and emit tokens
   slt_back #(
      .POSITION_BITS(POSITION_BITS), .WORD_PREFIX_CHARS(WORD_PREFIX_CHARS)
   ) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data, .rsp_valid, .rsp_stall, .rsp_data
   );

   `SLT_ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && !q_valid, "pop from empty queue")
   `SLT_ASSERT_IMP(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, ##1 rsp_valid,
      "response dropped while stalled")
   `SLT_ASSERT_IMP(a_kind_range, clock, reset, rsp_valid, rsp_data.token_kind <= slt_pkg::K_CHERR,
      "bad token kind")
endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Streams source text through stack_language_tokenizer_core and checks every
// token against an in-bench scanner model, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [31:0] POS_TOP = 32'hFFFF;
   localparam int PREFIX_CHARS = 5;
   localparam int CYCLE_LIMIT = 400000;

   // scanner modes of the model
   localparam logic [2:0] S_IDLE = 3'd0, S_COMMENT = 3'd1, S_NUMBER = 3'd2, S_WORD = 3'd3,
                          S_CHAR1 = 3'd4, S_CHAR2 = 3'd5, S_GREATER = 3'd6, S_LESS = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   slt_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   slt_pkg::rsp_type rsp_data;

   stack_language_tokenizer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // model state
   logic [2:0]  m_mode = S_IDLE;
   logic [63:0] m_acc = '0;
   logic        m_bad = 1'b0;
   logic [63:0] m_prefix = '0;
   int unsigned m_len = 0;
   logic [7:0]  m_chr = '0;
   logic [31:0] m_line = '0;
   logic [31:0] m_col = '0;

   slt_pkg::rsp_type expected_tokens[$];
   slt_pkg::rsp_type step_tokens[$];
   int errors = 0;
   int bytes_sent = 0;
   int tokens_seen = 0;
   longint cycles = 0;
   bit hold_off = 1'b0;   // long receiver stall request, cleared by the receiver

   function automatic void push_token(logic [4:0] kind, logic [63:0] value);
      slt_pkg::rsp_type t;
      t.token_kind = kind;
      t.token_value = value;
      t.token_line = m_line[15:0];
      t.token_column = m_col[15:0];
      t.last_of_run = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
      if (m_col < POS_TOP) m_col++;
   endfunction

   function automatic void flush_number();
      if (m_bad) push_token(slt_pkg::K_INV, '0);
      else push_token(slt_pkg::K_INT, m_acc);
   endfunction

   function automatic void flush_word();
      logic [4:0] k;
      k = slt_pkg::K_IDN;
      if (m_len == 2 && m_prefix == 64'h6966) k = slt_pkg::K_IF;
      if (m_len == 3) begin
         case (m_prefix)
            64'h6F7574: k = slt_pkg::K_OUT;
            64'h707574: k = slt_pkg::K_PUT;
            64'h647570: k = slt_pkg::K_DUP;
            64'h726F74: k = slt_pkg::K_ROT;
            64'h656E64: k = slt_pkg::K_END;
            default: ;
         endcase
      end
      if (m_len == 4) begin
         case (m_prefix)
            64'h64756D70: k = slt_pkg::K_DMP;
            64'h64757032: k = slt_pkg::K_DUP2;
            64'h73776170: k = slt_pkg::K_SWP;
            64'h64726F70: k = slt_pkg::K_DROP;
            default: ;
         endcase
      end
      push_token(k, '0);
   endfunction

   function automatic void clear_scanner();
      m_mode = S_IDLE; m_acc = '0; m_bad = 1'b0; m_prefix = '0;
      m_len = 0; m_chr = '0; m_line = '0; m_col = '0;
   endfunction

   // byte seen between tokens
   function automatic void scan_idle(logic [7:0] b);
      m_mode = S_IDLE;
      case (b)
         slt_pkg::CH_NL: begin
            if (m_line < POS_TOP) m_line++;
            m_col = '0;
         end
         slt_pkg::CH_DOLLAR: m_mode = S_COMMENT;
         slt_pkg::CH_SP, slt_pkg::CH_TAB: if (m_col < POS_TOP) m_col++;
         "+": push_token(slt_pkg::K_ADD, '0);
         "-": push_token(slt_pkg::K_SUB, '0);
         "*": push_token(slt_pkg::K_MUL, '0);
         "/": push_token(slt_pkg::K_DIV, '0);
         "%": push_token(slt_pkg::K_MOD, '0);
         slt_pkg::CH_GT: m_mode = S_GREATER;
         slt_pkg::CH_LT: m_mode = S_LESS;
         slt_pkg::CH_EQ: push_token(slt_pkg::K_EQ, '0);
         "!": push_token(slt_pkg::K_NT, '0);
         slt_pkg::CH_QUOTE: m_mode = S_CHAR1;
         default: begin
            if (b >= "0" && b <= "9") begin
               m_mode = S_NUMBER; m_acc = 64'(b - "0"); m_bad = 1'b0;
            end else begin
               m_mode = S_WORD; m_prefix = 64'(b); m_len = 1;
            end
         end
      endcase
   endfunction

   // tokenizes one byte and queues the tokens it yields
   function automatic void tokenize_byte(slt_pkg::req_type r);
      logic [7:0] b;
      bit done;
      logic [63:0] d;
      bit blank;
      b = r.source_byte;
      done = 0;
      blank = (b == slt_pkg::CH_SP || b == slt_pkg::CH_TAB || b == slt_pkg::CH_NL);
      step_tokens.delete();
      case (m_mode)
         S_GREATER, S_LESS: begin
            if (b == slt_pkg::CH_EQ) begin
               push_token(m_mode == S_GREATER ? slt_pkg::K_GE : slt_pkg::K_LE, '0);
               done = 1;
            end else push_token(m_mode == S_GREATER ? slt_pkg::K_GR : slt_pkg::K_LT, '0);
            m_mode = S_IDLE;
         end
         S_COMMENT: if (b == slt_pkg::CH_NL) m_mode = S_IDLE; else done = 1;
         S_NUMBER: begin
            if (blank) begin
               flush_number(); m_mode = S_IDLE;
            end else begin
               done = 1;
               if (b >= "0" && b <= "9") begin
                  d = 64'(b - "0");
                  if (!m_bad) begin
                     if (m_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) m_bad = 1'b1;
                     else m_acc = m_acc * 10 + d;
                  end
               end else m_bad = 1'b1;
            end
         end
         S_WORD: begin
            if (blank) begin
               flush_word(); m_mode = S_IDLE;
            end else begin
               if (m_len < PREFIX_CHARS) begin
                  m_prefix = (m_prefix << 8) | 64'(b); m_len++;
               end
               done = 1;
            end
         end
         S_CHAR1: begin
            m_chr = b; m_mode = S_CHAR2; done = 1;
         end
         S_CHAR2: begin
            if (b == slt_pkg::CH_QUOTE) push_token(slt_pkg::K_CHR, 64'(m_chr));
            else push_token(slt_pkg::K_CHERR, '0);
            m_mode = S_IDLE; done = 1;
         end
         default: m_mode = S_IDLE;
      endcase
      if (!done) scan_idle(b);
      if (r.is_final) begin
         case (m_mode)
            S_NUMBER: flush_number();
            S_WORD: flush_word();
            S_GREATER: push_token(slt_pkg::K_GR, '0);
            S_LESS: push_token(slt_pkg::K_LT, '0);
            S_CHAR1, S_CHAR2: push_token(slt_pkg::K_CHERR, '0);
            default: ;
         endcase
         push_token(slt_pkg::K_EOF, '0);
         clear_scanner();
      end
      if (step_tokens.size() > 0) step_tokens[$].last_of_run = 1'b1;
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
   endfunction

   // one request; blocks until accepted, leaves valid high for the caller
   task automatic send_byte(logic [7:0] b, logic fin);
      slt_pkg::req_type r;
      r.source_byte = b;
      r.is_final = fin;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_byte(r);
      bytes_sent++;
   endtask

   // random sender gap, only between bursts
   int burst_left = 0;
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(string s, bit fin_last);
      for (int i = 0; i < s.len(); i++) begin
         pace();
         send_byte(s[i], fin_last && i == s.len() - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() > 0) @(posedge clock);
   endtask

   // directed: operators, compares, keywords, literals, numbers, comments
   task automatic test_directed();
      send_text("+ - * / % = ! > < >= <= >x <x\n", 0);
      send_text("out put dump dup dup2 rot swap drop if end ifx swapp\tq\n", 0);
      send_text("0 18446744073709551615 18446744073709551616 12a3 'a' '\n' 'ab $ c\n", 0);
      send_text("'z", 1);
      send_text("abc", 1);
      send_text(">", 1);
      send_text("7", 1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
   endtask

   function automatic string random_word();
      string s;
      string kw[10] = '{"out", "put", "dump", "dup", "dup2", "rot", "swap", "drop",
                        "if", "end"};
      int n;
      case ($urandom_range(0, 5))
         0: s = kw[$urandom_range(0, 9)];
         1: begin
            s = "";
            n = $urandom_range(1, 21);
            for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
         end
         2: s = {"'", string'(8'($urandom_range(0, 255))), "'"};
         3: begin
            string ops[11] = '{"+", "-", "*", "/", "%", "=", "!", ">", "<", ">=", "<="};
            s = ops[$urandom_range(0, 10)];
         end
         4: begin
            s = "";
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
         end
         default: s = "$ note";
      endcase
      return s;
   endfunction

   // random: mostly well-formed programs, some raw byte noise
   task automatic test_random(int target);
      int start;
      string sep[3] = '{" ", "\t", "\n"};
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         if ($urandom_range(0, 4) == 0) begin
            pace();
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 15) == 0));
         end else begin
            send_text({random_word(), sep[$urandom_range(0, 2)]}, 0);
            if ($urandom_range(0, 12) == 0) send_text(random_word(), 1);
         end
      end
      send_byte(8'h0A, 1'b1);
   endtask

   // receiver blocked for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      hold_off = 1'b1;
      send_text("+ - * / % = ! + - * / % = ! + -", 1);
      wait_drained();
   endtask

   // receiver stall pattern plus the long hold-off
   int hold_count = 0;
   always @(posedge clock) begin
      if (hold_off) begin
         hold_off = 1'b0;
         rsp_stall <= 1'b1;
         hold_count <= 200;
      end else if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count - 1;
      end else if ((cycles % 64) < 16) begin
         rsp_stall <= 1'b0;  // stall-free stretch
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      slt_pkg::rsp_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_seen++;
         if (expected_tokens.size() == 0) begin
            $error("token with none expected: kind %0d", rsp_data.token_kind);
            errors++;
         end else begin
            e = expected_tokens.pop_front();
            if (rsp_data.token_kind !== e.token_kind) begin
               $error("token_kind expected %0d actual %0d", e.token_kind,
                      rsp_data.token_kind);
               errors++;
            end
            if (rsp_data.token_value !== e.token_value) begin
               $error("token_value expected %0d actual %0d", e.token_value,
                      rsp_data.token_value);
               errors++;
            end
            if (rsp_data.token_line !== e.token_line) begin
               $error("token_line expected %0d actual %0d", e.token_line,
                      rsp_data.token_line);
               errors++;
            end
            if (rsp_data.token_column !== e.token_column) begin
               $error("token_column expected %0d actual %0d", e.token_column,
                      rsp_data.token_column);
               errors++;
            end
            if (rsp_data.last_of_run !== e.last_of_run) begin
               $error("last_of_run expected %0d actual %0d", e.last_of_run,
                      rsp_data.last_of_run);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();   // sender pauses until all tokens are back
      test_backpressure();
      test_random(220);
      wait_drained();
      repeat (40) @(posedge clock);
      if (expected_tokens.size() > 0) begin
         $error("%0d tokens never arrived", expected_tokens.size());
         errors++;
      end
      $display("covered operators, compares, keywords, literals, numbers, comments,");
      $display("a long receiver hold-off and random programs: %0d bytes, %0d tokens",
               bytes_sent, tokens_seen);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
